### src/member_id_set_with_capacity_policy_defines.svh
// Assertion macros shared by the member ID set RTL.
`ifndef MEMBER_ID_SET_WITH_CAPACITY_POLICY_DEFINES_SVH
`define MEMBER_ID_SET_WITH_CAPACITY_POLICY_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define MIDSET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define MIDSET_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### src/midset_pkg.sv
// Types, codes and constants of the member ID set.
`timescale 1ns / 1ps
`default_nettype none
package midset_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 256;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned RIDX_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned CAP_W   = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CAP_W-1:0] RESET_INITIAL_CAPACITY = 16'd100;
  localparam logic [CAP_W-1:0] RESET_MINIMUM_CAPACITY = 16'd100;

  // Grow test: count * GROW_NUM > GROW_DEN * capacity (count above 94.9999 percent).
  localparam int unsigned GROW_NUM = 1000000;
  localparam int unsigned GROW_DEN = 949999;
  localparam int unsigned GROW_NUM_W = 20;
  localparam int unsigned GROW_DEN_W = 20;

  // floor(x / 5) for x below 2**18 equals (x * 52429) >> 18.
  localparam int unsigned SHRINK_RECIP = 52429;
  localparam int unsigned SHRINK_SHIFT = 18;

  typedef logic [CAP_W-1:0] cap_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_GROW   = 2'd1,
    EVT_SHRINK = 2'd2
  } evt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_CAPACITY = 1'b0,
    REG_MINIMUM_CAPACITY = 1'b1
  } reg_idx_t;

  // Outcome of one pass of the resize policy.
  typedef struct packed {
    logic valid;
    evt_t evt;
    cap_t cap;
  } rsz_res_t;

  // A zero capacity is loaded as one.
  function automatic cap_t load_capacity(input cap_t v);
    return (v == '0) ? cap_t'(1) : v;
  endfunction

endpackage
`default_nettype wire

### src/midset_in_if.sv
// Input channel of the member ID set: one command item per handshake.
`timescale 1ns / 1ps
`default_nettype none
interface midset_in_if;
  import midset_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [ID_W-1:0]   member_id;
  logic [RIDX_W-1:0]        read_index;

  modport source (output valid, output action, output member_id, output read_index,
                  input ready);
  modport sink   (input valid, input action, input member_id, input read_index,
                  output ready);
endinterface
`default_nettype wire

### src/midset_out_if.sv
// Output channel of the member ID set: one result item per handshake.
`timescale 1ns / 1ps
`default_nettype none
interface midset_out_if;
  import midset_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [COUNT_W-1:0]       member_count;
  logic [15:0]              withdrawn_total;
  logic [CAP_W-1:0]         capacity;
  logic [1:0]               resize_event;
  logic signed [ID_W-1:0]   read_value;
  logic                     add_rejected;

  modport source (output valid, output member_count, output withdrawn_total,
                  output capacity, output resize_event, output read_value,
                  output add_rejected, input ready);
  modport sink   (input valid, input member_count, input withdrawn_total,
                  input capacity, input resize_event, input read_value,
                  input add_rejected, output ready);
endinterface
`default_nettype wire

### src/midset_resize.sv
// Two-stage capacity resize policy: grow by 1.5x or shrink by 0.8x.
`timescale 1ns / 1ps
`default_nettype none
module midset_resize #(
  parameter int unsigned TABLE_DEPTH = midset_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
  input  wire midset_pkg::cap_t                     cap,
  input  wire midset_pkg::cap_t                     min_cap,
  output midset_pkg::rsz_res_t                      res
);
  import midset_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW = CW + GROW_NUM_W;
  localparam int unsigned RW = CAP_W + GROW_DEN_W;
  localparam int unsigned PW = (LW > RW) ? LW : RW;
  localparam int unsigned HW = (CW + 1 > CAP_W + 1) ? CW + 1 : CAP_W + 1;
  localparam int unsigned MW = CAP_W + 3;
  localparam int unsigned QW = CAP_W + 2 + CAP_W;

  logic [PW-1:0]    lhs;
  logic [PW-1:0]    rhs;
  logic             half_ok;
  logic             min_ok;
  cap_t             grown;
  cap_t             cap_s1;
  logic             v1;

  logic [CAP_W:0]   grow_sum;
  cap_t             min_eff;
  logic [QW-1:0]    shrink_prod;
  logic             grow_hit;

  assign min_eff  = (min_cap == '0) ? cap_t'(1) : min_cap;
  assign grow_sum = {1'b0, cap} + {2'b00, cap[CAP_W-1:1]};

  // First stage: products of the grow test and the side conditions.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    if (start) begin
      lhs     <= PW'(count) * PW'(GROW_NUM);
      rhs     <= PW'(cap) * PW'(GROW_DEN);
      half_ok <= (HW'({count, 1'b0}) <= HW'(cap));
      min_ok  <= (MW'({cap, 2'b00}) >= (MW'(min_eff) * MW'(5)));
      grown   <= grow_sum[CAP_W] ? '1 : grow_sum[CAP_W-1:0];
      cap_s1  <= cap;
    end
  end

  assign grow_hit    = (lhs > rhs);
  assign shrink_prod = QW'({cap_s1, 2'b00}) * QW'(SHRINK_RECIP);

  // Second stage: pick the new capacity.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= v1;
    end
    if (v1) begin
      if (grow_hit) begin
        res.evt <= EVT_GROW;
        res.cap <= grown;
      end else if (half_ok && min_ok) begin
        res.evt <= EVT_SHRINK;
        res.cap <= shrink_prod[SHRINK_SHIFT+CAP_W-1:SHRINK_SHIFT];
      end else begin
        res.evt <= EVT_NONE;
        res.cap <= cap_s1;
      end
    end
  end
endmodule
`default_nettype wire

### src/member_id_set_with_capacity_policy.sv
// Member ID set top level: table memory, command sequencer and result register.
// The time from accept to result valid depends on the action; for a remove it grows
// with the entries held before the remove and the matches, set by the table scan
// through the registered read port and the two-stage resize policy. A result that
// is not taken holds the item in its last state; the next item is accepted only
// once the result of the one before is posted. Reset (rst, synchronous) empties the
// table and sets capacity and minimum to 100.
`timescale 1ns / 1ps
`default_nettype none
`include "member_id_set_with_capacity_policy_defines.svh"
module member_id_set_with_capacity_policy #(
  parameter int unsigned TABLE_DEPTH = midset_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [midset_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [midset_pkg::CFG_DATA_W-1:0]   cfg_data,
  midset_in_if.sink                                in_ch,
  midset_out_if.source                             out_ch
);
  import midset_pkg::*;

  // Index width of the table, width of the entry count (which can reach the
  // depth itself), and a common width for comparing the read index to the count.
  localparam int unsigned IW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > RIDX_W) ? CW : RIDX_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_MOVE   = 6'b000100,
    S_RDWAIT = 6'b001000,
    S_RSZ    = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t              state;

  // Architectural state.
  logic [CW-1:0]       cnt;
  logic [15:0]         withdrawn;
  cap_t                cap;
  cap_t                min_cap;

  // Item being worked on.
  logic [ID_W-1:0]     key;
  logic [CW-1:0]       idx;
  logic                rsz_en;
  logic                rejected;
  logic                rd_ok;
  logic [ID_W-1:0]     rval;

  // Forwarding of the entry just moved into slot idx, so that the rescan of
  // that slot does not have to wait for the write to reach the memory.
  logic                fwd;
  logic [ID_W-1:0]     fwd_word;

  // Table memory with one write and one registered read port.
  logic [ID_W-1:0]     mem [TABLE_DEPTH];
  logic [IW-1:0]       rd_addr;
  logic [ID_W-1:0]     rdata;
  logic                mem_we;
  logic [IW-1:0]       wr_addr;
  logic [ID_W-1:0]     wr_data;

  // Result register.
  logic                out_valid;
  logic [COUNT_W-1:0]  o_count;
  logic [15:0]         o_withdrawn;
  cap_t                o_cap;
  evt_t                o_evt;
  logic [ID_W-1:0]     o_rval;
  logic                o_rej;

  logic                rsz_start;
  rsz_res_t            rsz_res;

  logic                accept;
  action_t             in_act;
  logic [CMPW-1:0]     ridx_ext;
  logic [CW-1:0]       idx_inc;
  logic [CW-1:0]       cnt_dec;
  logic [ID_W-1:0]     cur_word;
  logic                in_range;
  logic                out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_act      = action_t'(in_ch.action);
  assign ridx_ext    = CMPW'(in_ch.read_index);
  assign idx_inc     = idx + CW'(1);
  assign cnt_dec     = cnt - CW'(1);
  assign cur_word    = fwd ? fwd_word : rdata;
  assign in_range    = (idx < cnt);
  assign out_free    = !out_valid || out_ch.ready;

  // Memory address and write control. During the scan the next address is
  // chosen while the current entry is compared, so a slot without a match needs no
  // fresh read; a match instead fetches the last entry, which then moves into the slot.
  always_comb begin
    rd_addr = idx[IW-1:0];
    mem_we  = 1'b0;
    wr_addr = cnt[IW-1:0];
    wr_data = in_ch.member_id;
    unique case (state)
      S_IDLE: begin
        if (accept && in_act == ACT_READ) begin
          rd_addr = ridx_ext[IW-1:0];
        end else begin
          rd_addr = '0;
        end
        if (accept && in_act == ACT_ADD && cnt < CW'(TABLE_DEPTH)) begin
          mem_we = 1'b1;
        end
      end
      S_SCAN: begin
        if (in_range && cur_word == key) begin
          rd_addr = cnt_dec[IW-1:0];
        end else begin
          rd_addr = idx_inc[IW-1:0];
        end
      end
      S_MOVE: begin
        mem_we  = 1'b1;
        wr_addr = idx[IW-1:0];
        wr_data = rdata;
      end
      default: begin
        rd_addr = idx[IW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  midset_resize #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_resize (
    .clk     (clk),
    .rst     (rst),
    .start   (rsz_start),
    .count   (cnt),
    .cap     (cap),
    .min_cap (min_cap),
    .res     (rsz_res)
  );

  // Command sequencer. An add writes the table at once, unless it is full, and then
  // runs the resize policy; a remove scans slot by slot, each match moves the last
  // entry into the slot, which is then checked again, and the remove then runs the
  // resize policy; a read waits for the memory; every item ends in the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      withdrawn <= '0;
      cap       <= load_capacity(RESET_INITIAL_CAPACITY);
      min_cap   <= RESET_MINIMUM_CAPACITY;
      out_valid <= 1'b0;
      fwd       <= 1'b0;
      rsz_start <= 1'b0;
    end else begin
      rsz_start <= 1'b0;
      fwd       <= 1'b0;
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key      <= in_ch.member_id;
            idx      <= '0;
            rejected <= 1'b0;
            rval     <= '0;
            rd_ok    <= (ridx_ext < CMPW'(cnt));
            unique case (in_act)
              ACT_ADD: begin
                if (cnt < CW'(TABLE_DEPTH)) begin
                  cnt <= cnt + CW'(1);
                end else begin
                  rejected <= 1'b1;
                end
                rsz_en    <= 1'b1;
                rsz_start <= 1'b1;
                state     <= S_RSZ;
              end
              ACT_REMOVE: begin
                rsz_en <= 1'b1;
                state  <= S_SCAN;
              end
              ACT_READ: begin
                rsz_en <= 1'b0;
                state  <= S_RDWAIT;
              end
              ACT_NOP: begin
                rsz_en <= 1'b0;
                state  <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (in_range) begin
            if (cur_word == key) begin
              cnt <= cnt_dec;
              if (withdrawn != '1) begin
                withdrawn <= withdrawn + 16'd1;
              end
              state <= S_MOVE;
            end else begin
              idx <= idx_inc;
            end
          end else begin
            rsz_start <= 1'b1;
            state     <= S_RSZ;
          end
        end
        S_MOVE: begin
          fwd      <= 1'b1;
          fwd_word <= rdata;
          state    <= S_SCAN;
        end
        S_RDWAIT: begin
          rval  <= rd_ok ? rdata : '0;
          state <= S_FIN;
        end
        S_RSZ: begin
          if (rsz_res.valid) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            o_count     <= COUNT_W'(cnt);
            o_withdrawn <= withdrawn;
            o_rval      <= rval;
            o_rej       <= rejected;
            if (rsz_en) begin
              cap   <= rsz_res.cap;
              o_cap <= rsz_res.cap;
              o_evt <= rsz_res.evt;
            end else begin
              o_cap <= cap;
              o_evt <= EVT_NONE;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Configuration writes must only come while the block is idle (not enforced).
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_INITIAL_CAPACITY: cap     <= load_capacity(cfg_data);
          REG_MINIMUM_CAPACITY: min_cap <= cfg_data;
        endcase
      end
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.member_count    = o_count;
  assign out_ch.withdrawn_total = o_withdrawn;
  assign out_ch.capacity        = o_cap;
  assign out_ch.resize_event    = o_evt;
  assign out_ch.read_value      = o_rval;
  assign out_ch.add_rejected    = o_rej;

  `MIDSET_ASSERT(a_count_bound, cnt <= CW'(TABLE_DEPTH), "entry count beyond table depth")
  `MIDSET_ASSERT_IMPL(a_scan_index, state == S_SCAN, idx <= cnt,
                      "scan index past entry count")
  `MIDSET_ASSERT_IMPL(a_write_source, mem_we,
                      state == S_MOVE || (accept && in_act == ACT_ADD),
                      "table written outside an add or a move")
  `MIDSET_ASSERT_IMPL(a_withdrawn_mono, !$past(rst), withdrawn >= $past(withdrawn),
                      "withdrawal count went down")
  `MIDSET_ASSERT_IMPL(a_fin_to_idle, state == S_FIN && out_free,
                      ##1 (out_valid && state == S_IDLE), "result not posted on finish")

endmodule
`default_nettype wire
